### hdl/gpg_pkg.sv
`default_nettype none
package gpg_pkg;

    localparam int VALUE_W        = 61;
    localparam int SLOT_W         = 4;
    localparam int LEVEL_W        = 6;
    localparam int CFG_W          = 7;
    localparam int CFG_IDX_W      = 2;
    localparam int MAX_LEVELS_DEF = 16;
    localparam int MOD_BITS_DEF   = 61;

    localparam logic [CFG_W-1:0] BASE_BITS_RST   = 7'd16;
    localparam logic [CFG_W-1:0] LEVEL_COUNT_RST = 7'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT = 2'd1;

    typedef struct packed {
        logic [CFG_W-1:0] base_bits;
        logic [CFG_W-1:0] level_count;
    } gpg_cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_DOUBLE
    } gpg_state_t;

endpackage
`default_nettype wire

### hdl/gpg_in_if.sv
`default_nettype none
interface gpg_in_if;
    import gpg_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] modulus;
    logic [SLOT_W-1:0]  modulus_slot;

    modport source (output valid, modulus, modulus_slot, input ready);
    modport sink   (input valid, modulus, modulus_slot, output ready);
endinterface
`default_nettype wire

### hdl/gpg_out_if.sv
`default_nettype none
interface gpg_out_if;
    import gpg_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] gadget_value;
    logic [LEVEL_W-1:0] level;
    logic [SLOT_W-1:0]  row_slot;
    logic               last;

    modport source (output valid, gadget_value, level, row_slot, last, input ready);
    modport sink   (input valid, gadget_value, level, row_slot, last, output ready);
endinterface
`default_nettype wire

### hdl/gpg_cfg_if.sv
`default_nettype none
interface gpg_cfg_if;
    import gpg_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hdl/gpg_cfg_regs.sv
`default_nettype none
module gpg_cfg_regs (
    input  wire logic        clk,
    input  wire logic        rst_n,
    gpg_cfg_if.sink          cfg_ch,
    output gpg_pkg::gpg_cfg_t cfg
);
    import gpg_pkg::*;

    logic [CFG_W-1:0] base_bits_reg, base_bits_next;
    logic [CFG_W-1:0] level_count_reg, level_count_next;

    assign cfg_ch.ready = 1'b1;

    always_comb
    begin
        base_bits_next   = base_bits_reg;
        level_count_next = level_count_reg;
        if (cfg_ch.valid)
        begin
            // unknown indexes drop silently
            unique case (cfg_ch.index)
                CFG_BASE_BITS:   base_bits_next   = cfg_ch.data;
                CFG_LEVEL_COUNT: level_count_next = cfg_ch.data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_bits_reg   <= BASE_BITS_RST;
            level_count_reg <= LEVEL_COUNT_RST;
        end
        else
        begin
            base_bits_reg   <= base_bits_next;
            level_count_reg <= level_count_next;
        end
    end

    assign cfg.base_bits   = base_bits_reg;
    assign cfg.level_count = level_count_reg;

endmodule
`default_nettype wire

### hdl/gpg_mod_double.sv
`default_nettype none
module gpg_mod_double #(
    parameter int MOD_BITS = 61
) (
    input  wire logic [MOD_BITS-1:0] x,
    input  wire logic [MOD_BITS-1:0] q,
    output logic      [MOD_BITS-1:0] y
);
    logic [MOD_BITS:0]   dbl;
    logic [MOD_BITS+1:0] diff;

    // x < q, so one conditional subtract brings 2x back below q
    assign dbl  = {x, 1'b0};
    assign diff = {1'b0, dbl} - {2'b00, q};
    assign y    = diff[MOD_BITS+1] ? dbl[MOD_BITS-1:0] : diff[MOD_BITS-1:0];

endmodule
`default_nettype wire

### hdl/gpg_seq.sv
`default_nettype none
module gpg_seq #(
    parameter int MAX_LEVELS = 16,
    parameter int MOD_BITS   = 61
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  gpg_pkg::gpg_cfg_t         cfg,
    gpg_in_if.sink                    in_ch,
    gpg_out_if.source                 out_ch,
    output logic      [MOD_BITS-1:0]  dbl_x,
    output logic      [MOD_BITS-1:0]  dbl_q,
    input  wire logic [MOD_BITS-1:0]  dbl_y
);
    import gpg_pkg::*;

    localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

    gpg_state_t state_reg, state_next;

    logic [MOD_BITS-1:0] q_reg, q_next;
    logic [MOD_BITS-1:0] power_reg, power_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic                deg_reg, deg_next;
    logic [LVL_W-1:0]    level_reg, level_next;
    logic [CFG_W-1:0]    cnt_reg, cnt_next;

    logic                out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]  out_value_reg, out_value_next;
    logic [LEVEL_W-1:0]  out_level_reg, out_level_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic                out_last_reg, out_last_next;

    logic [63:0]         q_wide;
    logic [63:0]         power_wide;
    logic [MOD_BITS-1:0] q_in;
    logic                deg_in;
    logic [CFG_W-1:0]    levels_sat;
    logic                out_free;

    assign q_wide     = 64'(in_ch.modulus);
    assign q_in       = q_wide[MOD_BITS-1:0];
    assign deg_in     = (q_in < MOD_BITS'(2));
    assign power_wide = 64'(power_reg);
    assign levels_sat = (cfg.level_count > CFG_W'(MAX_LEVELS)) ? CFG_W'(MAX_LEVELS)
                                                              : cfg.level_count;
    assign out_free   = !out_valid_reg || out_ch.ready;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign dbl_x       = power_reg;
    assign dbl_q       = q_reg;

    always_comb
    begin
        state_next     = state_reg;
        q_next         = q_reg;
        power_next     = power_reg;
        slot_next      = slot_reg;
        deg_next       = deg_reg;
        level_next     = level_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_level_next = out_level_reg;
        out_slot_next  = out_slot_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    q_next     = q_in;
                    slot_next  = in_ch.modulus_slot;
                    deg_next   = deg_in;
                    power_next = deg_in ? '0 : MOD_BITS'(1);
                    level_next = LVL_W'(levels_sat - CFG_W'(1));
                    // zero levels: the word is consumed with no result
                    if (levels_sat != '0)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = power_wide[VALUE_W-1:0];
                    out_level_next = LEVEL_W'(level_reg);
                    out_slot_next  = slot_reg;
                    out_last_next  = (level_reg == '0);
                    if (level_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        level_next = level_reg - LVL_W'(1);
                        cnt_next   = '0;
                        if (!deg_reg && (cfg.base_bits != '0))
                        begin
                            state_next = ST_DOUBLE;
                        end
                    end
                end
            end
            ST_DOUBLE:
            begin
                power_next = dbl_y;
                cnt_next   = CFG_W'(cnt_reg + CFG_W'(1));
                if (CFG_W'(cnt_reg + CFG_W'(1)) == cfg.base_bits)
                begin
                    state_next = ST_EMIT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg         <= q_next;
        power_reg     <= power_next;
        slot_reg      <= slot_next;
        deg_reg       <= deg_next;
        level_reg     <= level_next;
        cnt_reg       <= cnt_next;
        out_value_reg <= out_value_next;
        out_level_reg <= out_level_next;
        out_slot_reg  <= out_slot_next;
        out_last_reg  <= out_last_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.gadget_value = out_value_reg;
    assign out_ch.level        = out_level_reg;
    assign out_ch.row_slot     = out_slot_reg;
    assign out_ch.last         = out_last_reg;

    a_stall_holds_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_valid_reg && !out_ch.ready) |=> state_reg == ST_EMIT)
        else $error("sequencer left EMIT while the output word was stalled");

    a_power_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE && !deg_reg) |-> (power_reg < q_reg))
        else $error("running power not reduced below the modulus");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_free && level_reg == '0)
        |=> (state_reg == ST_IDLE && out_valid_reg && out_last_reg))
        else $error("level zero did not close the run with a last word");

endmodule
`default_nettype wire

### hdl/gadget_power_generator.sv
`default_nettype none
// Gadget row generator: for each modulus word q it emits L = min(level_count, MAX_LEVELS)
// result words, level L-1 down to 0, the first carrying 1 and each next one the previous
// value times 2^base_bits mod q, with last set on level 0; a modulus below 2 gives 0 on
// every level. A single modular doubling unit (double plus conditional subtract) does one
// doubling per cycle; base_bits doublings lie between result words, and an output stall
// holds the block on the pending result word. A modulus below 2 or base_bits of 0 skips
// the doublings, and a level_count of 0 consumes the word with no result. The input
// is ready only while no run is in progress; the last result may still wait in the output
// register while the next modulus is taken.
module gadget_power_generator #(
    parameter int MAX_LEVELS = gpg_pkg::MAX_LEVELS_DEF,
    parameter int MOD_BITS   = gpg_pkg::MOD_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    gpg_in_if.sink    in_ch,
    gpg_out_if.source out_ch,
    gpg_cfg_if.sink   cfg_ch
);
    import gpg_pkg::*;

    gpg_cfg_t            cfg;
    logic [MOD_BITS-1:0] dbl_x;
    logic [MOD_BITS-1:0] dbl_q;
    logic [MOD_BITS-1:0] dbl_y;

    gpg_cfg_regs u_cfg_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_ch (cfg_ch),
        .cfg    (cfg)
    );

    gpg_mod_double #(
        .MOD_BITS (MOD_BITS)
    ) u_mod_double (
        .x (dbl_x),
        .q (dbl_q),
        .y (dbl_y)
    );

    gpg_seq #(
        .MAX_LEVELS (MAX_LEVELS),
        .MOD_BITS   (MOD_BITS)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .dbl_x  (dbl_x),
        .dbl_q  (dbl_q),
        .dbl_y  (dbl_y)
    );

endmodule
`default_nettype wire
